/* rtl/core/assert_macros.svh */
// Assertion macros shared by the page replacement RTL.
// Defining NO_ASSERTIONS turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define PRP_ASSERT_ALWAYS(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("check failed: condition does not hold");

// The antecedent at one edge implies the consequent at the next edge.
`define PRP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: next-cycle consequence does not hold");

`else

`define PRP_ASSERT_ALWAYS(name, clk, rstn, cond)
`define PRP_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/prp_pkg.sv */
// Shared types and constants of the page replacement block.
// No dependencies; used by prp_cell and page_replacement_policy.
package prp_pkg;

    // Fixed field widths of the ports.
    localparam int PORT_PAGE_W  = 16;
    localparam int POLICY_W     = 2;
    localparam int FRAMES_CFG_W = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int HIT_W        = 16;
    localparam int COUNT_W      = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES = 1'd1;

    // Replacement policies; the unused code behaves as FIFO.
    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_SC   = 2'd2;

    localparam logic [POLICY_W-1:0]     POLICY_RESET = POL_FIFO;
    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 5'd4;

    // Per-cell operations.
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD  = 2'd0;
    localparam cell_op_t CELL_SHIFT = 2'd1;
    localparam cell_op_t CELL_LOAD  = 2'd2;
    localparam cell_op_t CELL_MARK  = 2'd3;

    typedef struct packed {
        cell_op_t op;
        logic     new_bit;
    } cell_cmd_t;

endpackage

/* rtl/core/prp_cell.sv */
// One frame of the resident page row: page, reference bit and lookup compare.
// Depends on prp_pkg for the cell command type and operation codes.
module prp_cell #(
    parameter int PAGE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  prp_pkg::cell_cmd_t    cmd,
    input  logic [PAGE_BITS-1:0]  nb_page,
    input  logic                  nb_bit,
    input  logic [PAGE_BITS-1:0]  load_page,
    input  logic [PAGE_BITS-1:0]  lookup_page,
    input  logic                  occupied,
    input  logic                  seen_in,
    output logic                  match,
    output logic                  seen_out,
    output logic [PAGE_BITS-1:0]  page,
    output logic                  ref_bit
);
    import prp_pkg::*;

    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 bit_reg;
    logic                 bit_next;

    always_comb begin
        page_next = page_reg;
        bit_next  = bit_reg;
        case (cmd.op)
            CELL_SHIFT: begin
                page_next = nb_page;
                bit_next  = nb_bit;
            end
            CELL_LOAD: begin
                page_next = load_page;
                bit_next  = cmd.new_bit;
            end
            CELL_MARK: begin
                bit_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign match    = occupied && (page_reg == lookup_page);
    // Marks this cell and every newer one once the hit position has been passed.
    assign seen_out = seen_in | match;
    assign page     = page_reg;
    assign ref_bit  = bit_reg;

endmodule

/* rtl/core/page_replacement_policy.sv */
// Page replacement policy (FIFO, LRU, second chance) over a row of frame cells.
// An accepted item is looked up in the LOOK state; its result is registered once the
// output register is free, after a second chance eviction has rotated the marked
// oldest pages, at most the occupancy. A new item waits until the last one finishes.
// Reset: occupancy, reference bits and hit count clear; policy FIFO, 4 frames.
`include "assert_macros.svh"

module page_replacement_policy #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [prp_pkg::CFG_INDEX_W-1:0]      cfg_wr_index,
    input  logic [prp_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [prp_pkg::PORT_PAGE_W-1:0]      s_page_id,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic                                 m_victim_valid,
    output logic [prp_pkg::PORT_PAGE_W-1:0]      m_victim_page,
    output logic [prp_pkg::HIT_W-1:0]            m_hit_total,
    output logic [prp_pkg::COUNT_W-1:0]          m_resident_count
);
    import prp_pkg::*;

    localparam int OCC_W = $clog2(FRAMES + 1);
    localparam int CW    = (OCC_W > FRAMES_CFG_W) ? OCC_W : FRAMES_CFG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                    state_reg;
    logic                    state_next;
    logic [PAGE_BITS-1:0]    page_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;
    logic [POLICY_W-1:0]     policy_reg;
    logic [FRAMES_CFG_W-1:0] frames_reg;
    logic [HIT_W-1:0]        hit_cnt_reg;
    logic [HIT_W-1:0]        hit_cnt_next;

    logic                    m_valid_reg;
    logic                    m_hit_reg;
    logic                    m_victim_valid_reg;
    logic [PORT_PAGE_W-1:0]  m_victim_page_reg;
    logic [HIT_W-1:0]        m_hit_total_reg;
    logic [COUNT_W-1:0]      m_resident_count_reg;

    logic [PAGE_BITS-1:0]    cell_page [FRAMES];
    logic [FRAMES-1:0]       cell_bit;
    logic [FRAMES-1:0]       match;
    logic [FRAMES-1:0]       seen;
    logic [FRAMES-1:0]       occupied;
    cell_cmd_t               cmd [FRAMES];
    logic [PAGE_BITS-1:0]    load_page;

    logic                    look;
    logic                    hit;
    logic                    hit_bit;
    logic [CW-1:0]           frames_ext;
    logic [CW-1:0]           lim;
    logic                    full;
    logic                    pol_lru;
    logic                    pol_sc;
    logic                    rotate;
    logic                    out_free;
    logic                    finish;
    logic                    fill;
    logic                    evict;

    // Row of frame cells; cell 0 holds the oldest page.
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        logic [PAGE_BITS-1:0] nb_page;
        logic                 nb_bit;
        logic                 seen_in;

        if (g == FRAMES - 1) begin : g_end
            assign nb_page = '0;
            assign nb_bit  = 1'b0;
        end else begin : g_mid
            assign nb_page = cell_page[g+1];
            assign nb_bit  = cell_bit[g+1];
        end

        if (g == 0) begin : g_first
            assign seen_in = 1'b0;
        end else begin : g_rest
            assign seen_in = seen[g-1];
        end

        assign occupied[g] = OCC_W'(g) < occ_reg;

        prp_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd[g]),
            .nb_page     (nb_page),
            .nb_bit      (nb_bit),
            .load_page   (load_page),
            .lookup_page (page_reg),
            .occupied    (occupied[g]),
            .seen_in     (seen_in),
            .match       (match[g]),
            .seen_out    (seen[g]),
            .page        (cell_page[g]),
            .ref_bit     (cell_bit[g])
        );
    end

    always_comb begin
        look       = (state_reg == ST_LOOK);
        hit        = |match;
        hit_bit    = |(match & cell_bit);
        frames_ext = CW'(frames_reg);
        if (frames_ext == '0) begin
            lim = CW'(1);
        end else if (frames_ext > CW'(FRAMES)) begin
            lim = CW'(FRAMES);
        end else begin
            lim = frames_ext;
        end
        full     = CW'(occ_reg) >= lim;
        pol_lru  = (policy_reg == POL_LRU);
        pol_sc   = (policy_reg == POL_SC);
        // Second chance: a marked oldest page moves to the newest end, one per cycle.
        rotate   = look && pol_sc && !hit && full && cell_bit[0];
        out_free = !m_valid_reg || m_ready;
        finish   = look && !rotate && out_free;
        fill     = !hit && !full;
        evict    = !hit && full;
        load_page = rotate ? cell_page[0] : page_reg;
    end

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            logic below_last;
            logic is_last;
            logic is_tail;
            below_last = OCC_W'(i + 1) < occ_reg;
            is_last    = OCC_W'(i + 1) == occ_reg;
            is_tail    = OCC_W'(i) == occ_reg;
            cmd[i].op      = CELL_HOLD;
            cmd[i].new_bit = 1'b0;
            if (rotate) begin
                if (below_last) begin
                    cmd[i].op = CELL_SHIFT;
                end else if (is_last) begin
                    cmd[i].op = CELL_LOAD;
                end
            end else if (finish) begin
                if (hit && pol_lru) begin
                    if (seen[i] && below_last) begin
                        cmd[i].op = CELL_SHIFT;
                    end else if (is_last) begin
                        cmd[i].op      = CELL_LOAD;
                        cmd[i].new_bit = hit_bit;
                    end
                end else if (hit && pol_sc) begin
                    if (match[i]) begin
                        cmd[i].op = CELL_MARK;
                    end
                end else if (fill) begin
                    if (is_tail) begin
                        cmd[i].op = CELL_LOAD;
                    end
                end else if (evict) begin
                    if (below_last) begin
                        cmd[i].op = CELL_SHIFT;
                    end else if (is_last) begin
                        cmd[i].op = CELL_LOAD;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        hit_cnt_next = hit_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (finish) begin
                    state_next = ST_IDLE;
                    if (fill) begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    if (hit && (hit_cnt_reg != '1)) begin
                        hit_cnt_next = hit_cnt_reg + HIT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            hit_cnt_reg <= '0;
            policy_reg  <= POLICY_RESET;
            frames_reg  <= FRAMES_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            hit_cnt_reg <= hit_cnt_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_POLICY: policy_reg <= POLICY_W'(cfg_wr_data);
                    REG_FRAMES: frames_reg <= FRAMES_CFG_W'(cfg_wr_data);
                    default: begin
                    end
                endcase
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            page_reg <= PAGE_BITS'(s_page_id);
        end
        if (finish) begin
            m_hit_reg            <= hit;
            m_victim_valid_reg   <= evict;
            m_victim_page_reg    <= evict ? PORT_PAGE_W'(cell_page[0]) : '0;
            m_hit_total_reg      <= hit_cnt_next;
            m_resident_count_reg <= COUNT_W'(occ_next);
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_victim_valid   = m_victim_valid_reg;
    assign m_victim_page    = m_victim_page_reg;
    assign m_hit_total      = m_hit_total_reg;
    assign m_resident_count = m_resident_count_reg;

    `PRP_ASSERT_ALWAYS(a_occ_bound, aclk, aresetn, occ_reg <= OCC_W'(FRAMES))
    `PRP_ASSERT_ALWAYS(a_unique_match, aclk, aresetn, $onehot0(match))
    `PRP_ASSERT_NEXT(a_occ_kept, aclk, aresetn, finish && !fill, $stable(occ_reg))
    `PRP_ASSERT_NEXT(a_occ_grows, aclk, aresetn, finish && fill, occ_reg == $past(occ_reg) + 1'b1)

endmodule

/* dv/tb_page_replacement_policy.sv */
// Self-checking testbench for page_replacement_policy: FIFO, LRU and second chance
// replacement checked item by item against a behavioral predictor kept in this file.
// Depends on prp_pkg and the page_replacement_policy RTL only.
module tb_page_replacement_policy;
    timeunit 1ns;
    timeprecision 1ps;

    import prp_pkg::*;

    localparam int NUM_FRAMES = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int MAX_PRINTED = 40;
    // The fourth policy code has no name in the package; the block treats it as FIFO.
    localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

    typedef struct packed {
        logic                   hit;
        logic                   victim_valid;
        logic [PORT_PAGE_W-1:0] victim_page;
        logic [HIT_W-1:0]       hit_total;
        logic [COUNT_W-1:0]     resident_count;
    } page_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [PORT_PAGE_W-1:0]  s_page_id = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_hit;
    logic                    m_victim_valid;
    logic [PORT_PAGE_W-1:0]  m_victim_page;
    logic [HIT_W-1:0]        m_hit_total;
    logic [COUNT_W-1:0]      m_resident_count;

    page_replacement_policy i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_page_id        (s_page_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_victim_valid   (m_victim_valid),
        .m_victim_page    (m_victim_page),
        .m_hit_total      (m_hit_total),
        .m_resident_count (m_resident_count)
    );

    always #4 aclk = ~aclk;

    // Predictor state: resident pages ordered oldest first.
    logic [PORT_PAGE_W-1:0]  frame_page [NUM_FRAMES];
    logic                    frame_mark [NUM_FRAMES];
    int                      frame_count;
    logic [HIT_W-1:0]        hit_tally;
    logic [POLICY_W-1:0]     cur_policy;
    logic [FRAMES_CFG_W-1:0] cur_frames;

    logic [PORT_PAGE_W-1:0]  pages_pending [$];
    page_result_t            results_due [$];
    int                      issued_count = 0;
    int                      accepted_count = 0;
    int                      mismatch_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    logic                    hold_go = 1'b0;
    logic                    hold_done = 1'b0;
    int                      hold_left = 0;
    int                      quiet_cycles = 0;

    task automatic remove_frame(input int pos);
        for (int i = pos; i + 1 < frame_count; i++) begin
            frame_page[i] = frame_page[i + 1];
            frame_mark[i] = frame_mark[i + 1];
        end
        frame_count--;
    endtask

    task automatic append_frame(input logic [PORT_PAGE_W-1:0] page, input logic mark);
        if (frame_count < NUM_FRAMES) begin
            frame_page[frame_count] = page;
            frame_mark[frame_count] = mark;
            frame_count++;
        end
    endtask

    task automatic predict_reference(input logic [PORT_PAGE_W-1:0] page);
        int                     lim;
        int                     pos;
        int                     turns;
        logic                   mark;
        logic [PORT_PAGE_W-1:0] head;
        page_result_t           r;
        lim = int'(cur_frames);
        if (lim == 0) lim = 1;
        if (lim > NUM_FRAMES) lim = NUM_FRAMES;
        pos = -1;
        r = '0;
        for (int i = 0; i < frame_count; i++) begin
            if (pos < 0 && frame_page[i] == page) pos = i;
        end
        if (pos >= 0) begin
            r.hit = 1'b1;
            if (hit_tally != '1) hit_tally++;
            if (cur_policy == POL_LRU) begin
                mark = frame_mark[pos];
                remove_frame(pos);
                append_frame(page, mark);
            end else if (cur_policy == POL_SC) begin
                frame_mark[pos] = 1'b1;
            end
        end else if (frame_count < lim) begin
            append_frame(page, 1'b0);
        end else begin
            if (cur_policy == POL_SC) begin
                // Marked pages at the old end get their second chance: bit cleared, moved
                // to the new end. With every page marked, each one goes round once.
                turns = 0;
                while (turns < frame_count && frame_mark[0]) begin
                    head = frame_page[0];
                    remove_frame(0);
                    append_frame(head, 1'b0);
                    turns++;
                end
            end
            r.victim_valid = 1'b1;
            r.victim_page = frame_page[0];
            remove_frame(0);
            append_frame(page, 1'b0);
        end
        r.hit_total = hit_tally;
        r.resident_count = COUNT_W'(frame_count);
        results_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sender: a new item is offered only once the previous one has been taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_page_id <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_reference(s_page_id);
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pages_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_page_id <= pages_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", 32'({m_hit, m_victim_valid}), 32'h0);
            end else begin
                want = results_due.pop_front();
                if (m_hit !== want.hit)
                    report_mismatch("hit", 32'(m_hit), 32'(want.hit));
                if (m_victim_valid !== want.victim_valid)
                    report_mismatch("victim_valid", 32'(m_victim_valid),
                                    32'(want.victim_valid));
                if (m_victim_page !== want.victim_page)
                    report_mismatch("victim_page", 32'(m_victim_page), 32'(want.victim_page));
                if (m_hit_total !== want.hit_total)
                    report_mismatch("hit_total", 32'(m_hit_total), 32'(want.hit_total));
                if (m_resident_count !== want.resident_count)
                    report_mismatch("resident_count", 32'(m_resident_count),
                                    32'(want.resident_count));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $realtime, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        if (idx == REG_POLICY) cur_policy = data[POLICY_W-1:0];
        else cur_frames = data[FRAMES_CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_page(input logic [PORT_PAGE_W-1:0] page);
        pages_pending.push_back(page);
        issued_count++;
    endtask

    // Waits until every queued item has been taken and answered, then lets the
    // longest second chance rotation run out before anything is reconfigured.
    task automatic wait_drained;
        do @(posedge aclk);
        while (!(accepted_count == issued_count && results_due.size() == 0));
        repeat (2 + NUM_FRAMES + 8) @(posedge aclk);
    endtask

    initial begin
        int                     phase_policy [12] = '{0, 1, 2, 1, 2, 0, 2, 1, 3, 2, 0, 1};
        int                     phase_frames [12] = '{16, 1, 16, 8, 2, 31, 5, 16, 7, 1, 3, 20};
        int                     lim;
        logic [PORT_PAGE_W-1:0] pool_base;

        cur_policy = POLICY_RESET;
        cur_frames = FRAMES_RESET;
        frame_count = 0;
        hit_tally = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_page[i] = '0;
            frame_mark[i] = 1'b0;
        end
        send_idle_pct = 25;
        recv_idle_pct = 88;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset settings, FIFO with four frames: fill, hit, then evict the oldest.
        queue_page(16'h0000);
        queue_page(16'hFFFF);
        queue_page(16'h0000);
        queue_page(16'h0001);
        queue_page(16'h0002);
        queue_page(16'h0003);
        queue_page(16'hFFFF);
        wait_drained();

        // LRU with fewer frames than resident pages; the repeated 12 hits the newest page.
        write_register(REG_POLICY, CFG_DATA_W'(POL_LRU));
        write_register(REG_FRAMES, 5'd3);
        queue_page(16'h000A);
        queue_page(16'h000B);
        queue_page(16'h000C);
        queue_page(16'h000A);
        queue_page(16'h000C);
        queue_page(16'h000C);
        queue_page(16'h000D);
        wait_drained();

        // Second chance: mark every resident page, then a miss that rotates them all, then a hit and a plain miss.
        write_register(REG_POLICY, CFG_DATA_W'(POL_SC));
        write_register(REG_FRAMES, 5'd4);
        queue_page(16'h000B);
        queue_page(16'h000A);
        queue_page(16'h000C);
        queue_page(16'h000D);
        queue_page(16'h000E);
        queue_page(16'h000C);
        queue_page(16'h000F);
        wait_drained();

        // Unused policy code and zero frames.
        write_register(REG_POLICY, CFG_DATA_W'(POL_UNUSED));
        write_register(REG_FRAMES, 5'd0);
        queue_page(16'h0007);
        queue_page(16'h0008);
        queue_page(16'h0007);
        queue_page(16'h0009);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph * 3 / 12)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_register(REG_POLICY, CFG_DATA_W'(phase_policy[ph]));
            write_register(REG_FRAMES, CFG_DATA_W'(phase_frames[ph]));
            if (ph == 2) hold_go <= 1'b1;
            lim = phase_frames[ph];
            if (lim == 0) lim = 1;
            if (lim > NUM_FRAMES) lim = NUM_FRAMES;
            pool_base = PORT_PAGE_W'($urandom);
            // A small pool of pages a little larger than the frame count gives a
            // mix of hits and evictions; the rest are arbitrary page numbers.
            for (int n = 0; n < 34; n++) begin
                if ($urandom_range(99) < 80)
                    queue_page(pool_base + PORT_PAGE_W'($urandom_range(lim + 3)));
                else
                    queue_page(PORT_PAGE_W'($urandom));
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
